@@ hdl/acr_pkg.sv @@
// Shared types and constants for the antialiased circle rasterizer.
package acr_pkg;

  localparam int SLOTS = 16;

  localparam logic [7:0] COV_FULL = 8'd255;

  localparam logic [1:0] CFG_CENTER_X = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [1:0] CFG_RADIUS   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROOT,
    ST_COV,
    ST_ISSUE
  } st_t;

  // control half of one emission job
  typedef struct packed {
    logic [SLOTS-1:0] mask;
    logic             marker;
    logic             fin;
  } job_ctl_t;

endpackage

@@ hdl/antialiased_circle_rasterizer_core.sv @@
// Top level: antialiased circle rasterizer, one octant column per input beat.
// Each column beat passes the states MUL, ROOT, COV and ISSUE before its job reaches the emitter;
// the root is bit-serial (one bit per cycle); a restart with radius zero goes straight to ISSUE.
// A new column is taken only after the previous job has been handed to the emitter, which waits
// until the emitter has drained all of its up to 16 output beats; emission overlaps the next root.
// Reset (synchronous, rst_n low): configuration registers read zero, no circle active.
module antialiased_circle_rasterizer_core #(
  parameter int COORD_BITS         = 12,
  parameter int RADIUS_BITS        = 11,
  parameter int ROOT_FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_BITS:0]  out_pixel_x,
  output logic signed [COORD_BITS:0]  out_pixel_y,
  output logic [7:0]                  out_coverage,
  output logic                        out_pixel_valid,
  output logic                        out_last_of_tick,
  output logic                        out_finished
);

  localparam int RB = RADIUS_BITS;
  localparam int FB = ROOT_FRACTION_BITS;
  localparam int YW = RB + FB;
  localparam int MW = FB + 9;

  logic [COORD_BITS-1:0] cx_r, cy_r;
  logic [RB-1:0]         radius_r;

  acr_pkg::st_t state_r, state_nxt;
  logic [RB-1:0] column_r, column_nxt;
  logic          done_r, done_nxt;
  logic [RB-1:0] x_r, x_nxt, r_r, r_nxt;

  acr_pkg::job_ctl_t job_r, job_nxt;
  logic [RB-1:0]     jdx_r, jdx_nxt, jyi_r, jyi_nxt;
  logic [7:0]        jc0_r, jc0_nxt, jc1_r, jc1_nxt;

  logic          sqrt_start, sqrt_done, emit_idle, job_load;
  logic [2*RB-1:0] radicand;
  logic [YW-1:0] root;
  logic [2*RB-1:0] prod;

  logic [RB-1:0] yi;
  logic [FB-1:0] f;
  logic [FB:0]   inv;
  logic [MW-1:0] half, s0, s1;
  logic [7:0]    c0, c1;
  logic          diag0, diag1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      radius_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acr_pkg::CFG_CENTER_X: cx_r     <= cfg_data[COORD_BITS-1:0];
        acr_pkg::CFG_CENTER_Y: cy_r     <= cfg_data[COORD_BITS-1:0];
        acr_pkg::CFG_RADIUS:   radius_r <= cfg_data[RB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prod     = (2*RB)'(r_r - x_r) * (2*RB)'({1'b0, r_r} + {1'b0, x_r});
    radicand = (r_r > x_r) ? prod : '0;
  end

  always_comb begin
    yi    = root[YW-1:FB];
    f     = root[FB-1:0];
    inv   = {1'b1, {FB{1'b0}}} - {1'b0, f};
    half  = MW'(1) << (FB - 1);
    s0    = {inv, 8'd0} - MW'(inv) + half;
    s1    = {1'b0, f, 8'd0} - MW'(f) + half;
    c0    = s0[FB+7:FB];
    c1    = s1[FB+7:FB];
    diag0 = (x_r == yi);
    diag1 = ({1'b0, x_r} == ({1'b0, yi} + (RB+1)'(1)));
  end

  always_comb begin
    state_nxt  = state_r;
    column_nxt = column_r;
    done_nxt   = done_r;
    x_nxt      = x_r;
    r_nxt      = r_r;
    job_nxt    = job_r;
    jdx_nxt    = jdx_r;
    jyi_nxt    = jyi_r;
    jc0_nxt    = jc0_r;
    jc1_nxt    = jc1_r;
    in_ready   = 1'b0;
    sqrt_start = 1'b0;
    job_load   = 1'b0;
    unique case (state_r)
      acr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_restart) begin
            column_nxt = '0;
            done_nxt   = 1'b0;
            x_nxt      = '0;
            r_nxt      = radius_r;
            if (radius_r == '0) begin
              done_nxt       = 1'b1;
              job_nxt.mask   = acr_pkg::SLOTS'(1);
              job_nxt.marker = 1'b0;
              job_nxt.fin    = 1'b1;
              jdx_nxt        = '0;
              jyi_nxt        = '0;
              jc0_nxt        = acr_pkg::COV_FULL;
              jc1_nxt        = 8'd0;
              state_nxt      = acr_pkg::ST_ISSUE;
            end else begin
              state_nxt = acr_pkg::ST_MUL;
            end
          end else if (!done_r) begin
            x_nxt     = column_r;
            r_nxt     = radius_r;
            state_nxt = acr_pkg::ST_MUL;
          end
        end
      end
      acr_pkg::ST_MUL: begin
        sqrt_start = 1'b1;
        state_nxt  = acr_pkg::ST_ROOT;
      end
      acr_pkg::ST_ROOT: begin
        if (sqrt_done) state_nxt = acr_pkg::ST_COV;
      end
      acr_pkg::ST_COV: begin
        if (x_r > yi) begin
          done_nxt       = 1'b1;
          job_nxt.mask   = '0;
          job_nxt.marker = 1'b1;
          job_nxt.fin    = 1'b1;
        end else begin
          column_nxt     = x_r + RB'(1);
          job_nxt.marker = 1'b0;
          job_nxt.fin    = 1'b0;
          job_nxt.mask   = {(c1 != 8'd0) ? {diag1 ? 4'h0 : 4'hF, 4'hF} : 8'h00,
                            (c0 != 8'd0) ? {diag0 ? 4'h0 : 4'hF, 4'hF} : 8'h00};
        end
        jdx_nxt   = x_r;
        jyi_nxt   = yi;
        jc0_nxt   = c0;
        jc1_nxt   = c1;
        state_nxt = acr_pkg::ST_ISSUE;
      end
      acr_pkg::ST_ISSUE: begin
        if (emit_idle) begin
          job_load  = 1'b1;
          state_nxt = acr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = acr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= acr_pkg::ST_IDLE;
      column_r <= '0;
      done_r   <= 1'b1;
      job_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      column_r <= column_nxt;
      done_r   <= done_nxt;
      job_r    <= job_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    r_r   <= r_nxt;
    jdx_r <= jdx_nxt;
    jyi_r <= jyi_nxt;
    jc0_r <= jc0_nxt;
    jc1_r <= jc1_nxt;
  end

  acr_sqrt #(
    .RADIUS_BITS        (RADIUS_BITS),
    .ROOT_FRACTION_BITS (ROOT_FRACTION_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  acr_emit #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_load         (job_load),
    .job              (job_r),
    .job_dx           (jdx_r),
    .job_yi           (jyi_r),
    .job_c0           (jc0_r),
    .job_c1           (jc1_r),
    .center_x         (cx_r),
    .center_y         (cy_r),
    .idle             (emit_idle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_coverage     (out_coverage),
    .out_pixel_valid  (out_pixel_valid),
    .out_last_of_tick (out_last_of_tick),
    .out_finished     (out_finished)
  );

endmodule

@@ hdl/acr_sqrt.sv @@
// Digit-serial fixed-point square root, one root bit per cycle.
module acr_sqrt #(
  parameter int RADIUS_BITS        = 11,
  parameter int ROOT_FRACTION_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic [2*RADIUS_BITS-1:0]                  radicand,
  output logic                                      done,
  output logic [RADIUS_BITS+ROOT_FRACTION_BITS-1:0] root
);

  localparam int NW   = 2 * RADIUS_BITS;
  localparam int YW   = RADIUS_BITS + ROOT_FRACTION_BITS;
  localparam int RW   = YW + 2;
  localparam int CNTW = $clog2(YW + 1);

  logic [NW-1:0]   n_r, n_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic [YW-1:0]   root_r, root_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;

  always_comb begin
    rem_sh   = {rem_r[RW-3:0], n_r[NW-1:NW-2]};
    trial    = {root_r, 2'b01};
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNTW'(YW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[NW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[YW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[YW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ hdl/acr_emit.sv @@
// Point sequencer: walks the symmetric slots of one column into the output register.
module acr_emit #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_load,
  input  acr_pkg::job_ctl_t           job,
  input  logic [RADIUS_BITS-1:0]      job_dx,
  input  logic [RADIUS_BITS-1:0]      job_yi,
  input  logic [7:0]                  job_c0,
  input  logic [7:0]                  job_c1,
  input  logic [COORD_BITS-1:0]       center_x,
  input  logic [COORD_BITS-1:0]       center_y,
  output logic                        idle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_BITS:0]  out_pixel_x,
  output logic signed [COORD_BITS:0]  out_pixel_y,
  output logic [7:0]                  out_coverage,
  output logic                        out_pixel_valid,
  output logic                        out_last_of_tick,
  output logic                        out_finished
);

  localparam int PW = COORD_BITS + 1;
  localparam int OW = RADIUS_BITS + 1;
  localparam int SW = (PW > OW) ? PW : OW;

  logic [acr_pkg::SLOTS-1:0] mask_r, mask_nxt, mask_left;
  logic                      marker_r, marker_nxt;
  logic                      fin_r;
  logic [RADIUS_BITS-1:0]    dx_r, yi_r;
  logic [7:0]                c0_r, c1_r;
  logic                      ov_r, ov_nxt;

  logic [PW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [7:0]    cov_r, cov_nxt;
  logic          pv_r, pv_nxt, last_r, last_nxt, fin_o_r, fin_o_nxt;

  logic [3:0]    sel;
  logic [OW-1:0] dyg, dxe, ox, oy;
  logic [SW-1:0] cxe, cye, sx, sy;
  logic          take;

  always_comb begin
    sel = 4'd0;
    for (int i = acr_pkg::SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = 4'(i);
    end
  end

  always_comb begin
    dyg = sel[3] ? ({1'b0, yi_r} + OW'(1)) : {1'b0, yi_r};
    dxe = {1'b0, dx_r};
    ox  = sel[2] ? dyg : dxe;
    oy  = sel[2] ? dxe : dyg;
    cxe = SW'($signed(center_x));
    cye = SW'($signed(center_y));
    sx  = sel[0] ? (cxe - SW'(ox)) : (cxe + SW'(ox));
    sy  = sel[1] ? (cye - SW'(oy)) : (cye + SW'(oy));
  end

  assign take      = !ov_r || out_ready;
  assign mask_left = mask_r & ~(acr_pkg::SLOTS'(1) << sel);

  always_comb begin
    mask_nxt   = mask_r;
    marker_nxt = marker_r;
    ov_nxt     = ov_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    cov_nxt    = cov_r;
    pv_nxt     = pv_r;
    last_nxt   = last_r;
    fin_o_nxt  = fin_o_r;
    if (job_load) begin
      mask_nxt   = job.mask;
      marker_nxt = job.marker;
    end else if (take) begin
      if (marker_r) begin
        marker_nxt = 1'b0;
        ov_nxt     = 1'b1;
        px_nxt     = '0;
        py_nxt     = '0;
        cov_nxt    = 8'd0;
        pv_nxt     = 1'b0;
        last_nxt   = 1'b1;
        fin_o_nxt  = 1'b1;
      end else if (mask_r != '0) begin
        mask_nxt  = mask_left;
        ov_nxt    = 1'b1;
        px_nxt    = sx[PW-1:0];
        py_nxt    = sy[PW-1:0];
        cov_nxt   = sel[3] ? c1_r : c0_r;
        pv_nxt    = 1'b1;
        last_nxt  = (mask_left == '0);
        fin_o_nxt = fin_r && (mask_left == '0);
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      marker_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      mask_r   <= mask_nxt;
      marker_r <= marker_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      fin_r <= job.fin;
      dx_r  <= job_dx;
      yi_r  <= job_yi;
      c0_r  <= job_c0;
      c1_r  <= job_c1;
    end
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    cov_r   <= cov_nxt;
    pv_r    <= pv_nxt;
    last_r  <= last_nxt;
    fin_o_r <= fin_o_nxt;
  end

  assign idle             = (mask_r == '0) && !marker_r && !ov_r;
  assign out_valid        = ov_r;
  assign out_pixel_x      = $signed(px_r);
  assign out_pixel_y      = $signed(py_r);
  assign out_coverage     = cov_r;
  assign out_pixel_valid  = pv_r;
  assign out_last_of_tick = last_r;
  assign out_finished     = fin_o_r;

endmodule
